FILE: src/mfps_pkg.sv
// Package for the maximum falling path sum block.
// Holds the payload structs, the front-to-back control struct and the fixed widths.
// No dependencies.
package mfps_pkg;

  localparam int unsigned CfgW   = 9;
  localparam int unsigned ValueW = 32;
  localparam int unsigned SumW   = 48;

  // Column count after reset.
  localparam logic [CfgW-1:0] ColumnsReset = 9'd256;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef struct packed {
    logic signed [ValueW-1:0] cell_value;
    logic                     last_cell;
  } in_item_t;

  typedef struct packed {
    logic signed [SumW-1:0] max_path_sum;
    logic                   overflow_flag;
  } out_item_t;

  // A cell after classification by the front end.
  typedef struct packed {
    logic signed [ValueW-1:0] cell_value;
    logic                     last_cell;
    logic                     first_row;  // cell belongs to the top row
    logic                     row_start;  // cell sits in column zero
    logic                     has_right;  // an above-right neighbor exists
  } cell_ctl_t;

endpackage

FILE: src/mfps_front.sv
// Front end of the maximum falling path sum block: column register, row tracking
// and classification of each accepted cell. Depends on mfps_pkg.
module mfps_front #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned ColW        = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mfps_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mfps_pkg::in_item_t          in_item_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output mfps_pkg::cell_ctl_t         push_ctl_o,
  output logic [ColW-1:0]             push_col_o,
  output logic [ColW-1:0]             push_col_b_o
);

  localparam int unsigned CntW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned CmpW = (CntW > mfps_pkg::CfgW) ? CntW : mfps_pkg::CfgW;

  logic [mfps_pkg::CfgW-1:0] cols_q;
  logic [ColW-1:0]           col_q, col_d;
  logic                      first_q, first_d;

  logic [CmpW-1:0] cols_raw, cols_eff, col_ext, j_plus;
  logic [ColW-1:0] j;
  logic            wrap, first, has_right;

  always_comb begin
    cols_raw = CmpW'(cols_q);
    if (cols_raw == '0) begin
      cols_eff = CmpW'(1);
    end else if (cols_raw > CmpW'(MAX_COLUMNS)) begin
      cols_eff = CmpW'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_raw;
    end
    // A row left unfinished by a smaller column count is taken as ended.
    col_ext   = CmpW'(col_q);
    wrap      = col_ext >= cols_eff;
    j         = wrap ? '0 : col_q;
    first     = first_q & ~wrap;
    j_plus    = CmpW'(j) + CmpW'(1);
    has_right = j_plus < cols_eff;
  end

  assign in_ready_o = ~q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    push_ctl_o.cell_value = in_item_i.cell_value;
    push_ctl_o.last_cell  = in_item_i.last_cell;
    push_ctl_o.first_row  = first;
    push_ctl_o.row_start  = (j == '0);
    push_ctl_o.has_right  = has_right;
    push_col_o            = j;
    push_col_b_o          = has_right ? j_plus[ColW-1:0] : j;
  end

  always_comb begin
    col_d   = col_q;
    first_d = first_q;
    if (push_o) begin
      if (in_item_i.last_cell) begin
        col_d   = '0;
        first_d = 1'b1;
      end else if (!has_right) begin
        col_d   = '0;
        first_d = 1'b0;
      end else begin
        col_d   = j_plus[ColW-1:0];
        first_d = first;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= mfps_pkg::ColumnsReset;
      col_q   <= '0;
      first_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        cols_q <= cfg_data_i;
      end
      col_q   <= col_d;
      first_q <= first_d;
    end
  end

endmodule

FILE: src/mfps_queue.sv
// Two-entry queue between the front end and the back end of the path sum block.
// Also exposes the head as it will be after the coming clock edge. Depends on mfps_pkg.
module mfps_queue #(
  parameter int unsigned ColW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mfps_pkg::cell_ctl_t push_ctl_i,
  input  logic [ColW-1:0]     push_col_i,
  input  logic [ColW-1:0]     push_col_b_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output mfps_pkg::cell_ctl_t head_ctl_o,
  output logic [ColW-1:0]     head_col_o,
  output logic [ColW-1:0]     nxt_col_o,
  output logic [ColW-1:0]     nxt_col_b_o
);

  typedef struct packed {
    mfps_pkg::cell_ctl_t ctl;
    logic [ColW-1:0]     col;
    logic [ColW-1:0]     col_b;
  } slot_t;

  slot_t       slot0_q, slot0_d, slot1_q, slot1_d, incoming;
  logic [1:0]  cnt_q, cnt_d, remain;

  always_comb begin
    incoming.ctl   = push_ctl_i;
    incoming.col   = push_col_i;
    incoming.col_b = push_col_b_i;
    slot0_d = pop_i ? slot1_q : slot0_q;
    slot1_d = slot1_q;
    remain  = cnt_q - {1'b0, pop_i};
    if (push_i) begin
      if (remain == 2'd0) begin
        slot0_d = incoming;
      end else begin
        slot1_d = incoming;
      end
    end
    cnt_d = remain + {1'b0, push_i};
  end

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_ctl_o   = slot0_q.ctl;
  assign head_col_o   = slot0_q.col;
  assign nxt_col_o    = slot0_d.col;
  assign nxt_col_b_o  = slot0_d.col_b;

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_o |-> !pop_i)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i && cnt_q == 2'd1) |=> !head_valid_o)
    else $error("queue count wrong after last entry left");
`endif

endmodule

FILE: src/mfps_back.sv
// Back end of the path sum block: row store, neighbor maximum, saturating add,
// running row maximum and the output register. Depends on mfps_pkg.
module mfps_back #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned ColW        = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  mfps_pkg::cell_ctl_t head_ctl_i,
  input  logic [ColW-1:0]     head_col_i,
  input  logic [ColW-1:0]     nxt_col_i,
  input  logic [ColW-1:0]     nxt_col_b_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mfps_pkg::out_item_t out_item_o
);

  localparam int unsigned SumW  = mfps_pkg::SumW;
  localparam int unsigned WideW = SumW + 1;

  logic signed [SumW-1:0] row_mem [MAX_COLUMNS];

  logic signed [SumW-1:0] rd_a_q, rd_b_q;
  logic signed [SumW-1:0] held_left_q, run_q;
  logic                   sticky_q;
  logic                   out_valid_q;
  mfps_pkg::out_item_t    out_item_q;

  logic                   exec;
  logic signed [SumW-1:0] best, sat_val, fresh, run_new;
  logic signed [WideW-1:0] sum_w;
  logic                   sum_ovf, ovf, sticky_new;

  // A last cell waits until the output register can take its result.
  assign exec  = head_valid_i & (~head_ctl_i.last_cell | ~out_valid_q | out_ready_i);
  assign pop_o = exec;

  always_comb begin
    best = rd_a_q;
    if (!head_ctl_i.row_start && held_left_q > best) begin
      best = held_left_q;
    end
    if (head_ctl_i.has_right && rd_b_q > best) begin
      best = rd_b_q;
    end
    sum_w   = WideW'(best) + WideW'(head_ctl_i.cell_value);
    sum_ovf = sum_w[WideW-1] != sum_w[WideW-2];
    if (sum_ovf) begin
      sat_val = sum_w[WideW-1] ? mfps_pkg::SumMin : mfps_pkg::SumMax;
    end else begin
      sat_val = sum_w[SumW-1:0];
    end
    fresh      = head_ctl_i.first_row ? SumW'(head_ctl_i.cell_value) : sat_val;
    ovf        = ~head_ctl_i.first_row & sum_ovf;
    sticky_new = sticky_q | ovf;
    if (head_ctl_i.row_start || fresh > run_q) begin
      run_new = fresh;
    end else begin
      run_new = run_q;
    end
  end

  // Row store with two read ports; a read of the entry written at the same
  // edge takes the new value.
  always_ff @(posedge clk_i) begin
    if (exec) begin
      row_mem[head_col_i] <= fresh;
    end
    rd_a_q <= (exec && head_col_i == nxt_col_i) ? fresh : row_mem[nxt_col_i];
    rd_b_q <= (exec && head_col_i == nxt_col_b_i) ? fresh : row_mem[nxt_col_b_i];
  end

  always_ff @(posedge clk_i) begin
    if (exec && head_ctl_i.last_cell) begin
      out_item_q.max_path_sum  <= run_new;
      out_item_q.overflow_flag <= sticky_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_left_q <= '0;
      run_q       <= mfps_pkg::SumMin;
      sticky_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        if (!head_ctl_i.first_row) begin
          held_left_q <= rd_a_q;
        end
        if (head_ctl_i.last_cell) begin
          run_q    <= mfps_pkg::SumMin;
          sticky_q <= 1'b0;
        end else begin
          run_q    <= run_new;
          sticky_q <= sticky_new;
        end
      end
      if (exec && head_ctl_i.last_cell) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && head_ctl_i.last_cell) |=> (!sticky_q && run_q == mfps_pkg::SumMin))
    else $error("matrix state not restarted after last cell");
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(exec && head_ctl_i.last_cell))
    else $error("result shown without a last cell");
  a_sticky_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(sticky_q) |-> $past(exec && head_ctl_i.last_cell))
    else $error("overflow flag cleared inside a matrix");
`endif

endmodule

FILE: src/max_falling_path_sum_core.sv
// Top level of the maximum falling path sum block.
// Connects mfps_front, mfps_queue and mfps_back; depends on mfps_pkg.
//
// Usage: matrix cells enter on the input channel (in_valid_i / in_ready_o /
// in_item_i) in row-major order, one transaction per cell, with last_cell set
// on the final cell of the matrix. The column count is written through
// cfg_we_i / cfg_data_i while no transaction is in flight; zero acts as one
// and counts above MAX_COLUMNS act as MAX_COLUMNS.
// Each final cell produces one transaction on the output channel
// (out_valid_o / out_ready_i / out_item_o) carrying the largest falling path
// sum of the last row and a flag that is set if any sum saturated at 48 bits.
// Throughput is one cell per cycle, set by the single read-modify-write of the
// row store per cell, while the queue has room and no final cell is held.
// out_valid_o rises once a final cell has passed the queue and been registered.
// When the receiver stalls, the finished result waits in the output register
// while cells keep flowing; only a second final cell holds at the head of the
// two-entry queue, and the input stalls once that queue is full.
// Reset clears the queue, the output register and the row tracking and sets
// the column count to 256; the row store is not cleared and needs no pass.
module max_falling_path_sum_core #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mfps_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mfps_pkg::in_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output mfps_pkg::out_item_t       out_item_o
);

  // Bits needed to address one column of the row store.
  localparam int unsigned ColW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic                push;
  mfps_pkg::cell_ctl_t push_ctl;
  logic [ColW-1:0]     push_col, push_col_b;
  logic                q_full;
  logic                pop;
  logic                head_valid;
  mfps_pkg::cell_ctl_t head_ctl;
  logic [ColW-1:0]     head_col;
  logic [ColW-1:0]     nxt_col, nxt_col_b;

  // The front end tracks the column and row of each cell as it is accepted,
  // so the back end never needs the column count.
  mfps_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .ColW        (ColW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_ctl_o   (push_ctl),
    .push_col_o   (push_col),
    .push_col_b_o (push_col_b)
  );

  // The queue also reports its next head so the back end can start the row
  // store reads before that entry becomes the head.
  mfps_queue #(
    .ColW (ColW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ctl_i   (push_ctl),
    .push_col_i   (push_col),
    .push_col_b_i (push_col_b),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_ctl_o   (head_ctl),
    .head_col_o   (head_col),
    .nxt_col_o    (nxt_col),
    .nxt_col_b_o  (nxt_col_b)
  );

  mfps_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .ColW        (ColW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_ctl_i   (head_ctl),
    .head_col_i   (head_col),
    .nxt_col_i    (nxt_col),
    .nxt_col_b_i  (nxt_col_b),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
